### src/address_redirect_binary_search_top_assert.svh
// assertion macros for the address redirect search block
`ifndef ADDRESS_REDIRECT_BINARY_SEARCH_TOP_ASSERT_SVH
`define ADDRESS_REDIRECT_BINARY_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, checked on clk and disabled during reset
`define ARBS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk and disabled during reset
`define ARBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/arbs_pkg.sv
// shared types and constants for the address redirect search block
package arbs_pkg;

	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;
	localparam int OUT_ADDR_W = 48;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic load_in;
		logic rd_en;
		logic step;
		logic load_out;
	} arbs_cmd_t;

	typedef struct packed {
		logic searchable;
		logic eq;
		logic empty_next;
	} arbs_stat_t;

endpackage

### src/arbs_dpath.sv
// table memories, search bounds, compare and result registers
module arbs_dpath #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ADDR_WIDTH  = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  arbs_pkg::arbs_cmd_t          cmd,
	output arbs_pkg::arbs_stat_t         stat,
	input  logic                         cfg_we,
	input  logic [arbs_pkg::COUNT_W-1:0] cfg_count,
	input  logic                         command,
	input  logic [arbs_pkg::INDEX_W-1:0] entry_index,
	input  logic [ADDR_WIDTH-1:0]        entry_source,
	input  logic [ADDR_WIDTH-1:0]        entry_target,
	input  logic [ADDR_WIDTH-1:0]        lookup_address,
	input  logic                         is_owner,
	output logic [ADDR_WIDTH-1:0]        result_address,
	output logic                         hit
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam logic [ADDR_WIDTH-1:0] OUT_MASK =
		ADDR_WIDTH'({arbs_pkg::OUT_ADDR_W{1'b1}});

	logic [ADDR_WIDTH-1:0] src_mem [TABLE_DEPTH];
	logic [ADDR_WIDTH-1:0] tgt_mem [TABLE_DEPTH];

	logic [arbs_pkg::COUNT_W-1:0] count_q;
	logic [ADDR_WIDTH-1:0] key_q;
	logic [ADDR_WIDTH-1:0] rd_src_q;
	logic [ADDR_WIDTH-1:0] rd_tgt_q;
	logic [ADDR_WIDTH-1:0] res_addr_q;
	logic                  res_hit_q;
	logic [ADDR_WIDTH-1:0] out_addr_q;
	logic                  out_hit_q;
	logic [NW-1:0]         lo_q;
	logic [NW-1:0]         hi_q;

	logic [NW-1:0]    n_sat;
	logic [NW-1:0]    span;
	logic [NW-1:0]    mid;
	logic [NW-1:0]    mid_inc;
	logic [IDX_W-1:0] mid_idx;
	logic             is_write;
	logic             idx_ok;
	logic             lt;

	always_comb begin
		if (32'(count_q) > 32'(TABLE_DEPTH)) begin
			n_sat = NW'(TABLE_DEPTH);
		end else begin
			n_sat = NW'(count_q);
		end
	end

	// lower midpoint of the half-open range [lo, hi)
	assign span    = hi_q - lo_q - NW'(1);
	assign mid     = lo_q + (span >> 1);
	assign mid_inc = mid + NW'(1);
	assign mid_idx = mid[IDX_W-1:0];

	assign is_write = (command == arbs_pkg::CMD_WRITE);
	assign idx_ok   = (32'(entry_index) < 32'(TABLE_DEPTH));
	assign lt       = (rd_src_q < key_q);

	assign stat.searchable = (command == arbs_pkg::CMD_LOOKUP) && is_owner && (n_sat != '0);
	assign stat.eq         = (rd_src_q == key_q);
	assign stat.empty_next = lt ? (mid_inc >= hi_q) : (mid <= lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in && is_write && idx_ok) begin
			src_mem[IDX_W'(entry_index)] <= entry_source;
			tgt_mem[IDX_W'(entry_index)] <= entry_target;
		end
		if (cmd.rd_en) begin
			rd_src_q <= src_mem[mid_idx];
			rd_tgt_q <= tgt_mem[mid_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_q      <= lookup_address;
			res_addr_q <= is_write ? '0 : lookup_address;
			res_hit_q  <= 1'b0;
			lo_q       <= '0;
			hi_q       <= n_sat;
		end else if (cmd.step) begin
			if (stat.eq) begin
				res_addr_q <= rd_tgt_q;
				res_hit_q  <= 1'b1;
			end else if (lt) begin
				lo_q <= mid_inc;
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.load_out) begin
			out_addr_q <= res_addr_q & OUT_MASK;
			out_hit_q  <= res_hit_q;
		end
	end

	assign result_address = out_addr_q;
	assign hit            = out_hit_q;

endmodule

### src/arbs_ctrl.sv
// sequencer for write, pass-through and binary-search lookup items
`include "address_redirect_binary_search_top_assert.svh"

module arbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output arbs_pkg::arbs_cmd_t  cmd,
	input  arbs_pkg::arbs_stat_t stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	assign in_stall     = (state_q != S_IDLE);
	assign cmd.load_in  = (state_q == S_IDLE) && in_valid;
	assign cmd.rd_en    = (state_q == S_READ);
	assign cmd.step     = (state_q == S_CMP);
	assign cmd.load_out = (state_q == S_DONE) && out_free;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= stat.searchable ? S_READ : S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					// stop on a match or when the range has closed
					if (stat.eq || stat.empty_next) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ARBS_ASSERT_NEXT(a_search_start, (state_q == S_IDLE) && in_valid && stat.searchable, state_q == S_READ, "searchable lookup did not start a probe")
	`ARBS_ASSERT_NEXT(a_read_then_cmp, state_q == S_READ, state_q == S_CMP, "probe read not followed by compare")
	`ARBS_ASSERT_SAME(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "result shown without a finished item")

endmodule

### src/address_redirect_binary_search_top.sv
// Address redirect table with binary-search lookup.
// Input channel: in_valid / in_stall, one item per transfer. command selects a table
// write (entry_index, entry_source, entry_target) or a lookup (lookup_address, is_owner).
// Output channel: out_valid / out_stall, one result per item: result_address and hit.
// Writes, and lookups with is_owner clear or a zero entry_count, give their result without touching the search.
// Config channel: cfg_valid / cfg_ready with entry_count as data; cfg_ready is always high.
// After the input transfer, a write or pass-through item goes straight to the done state,
// and a lookup makes p probes, p <= ceil(log2(entry_count + 1)), before it gets there;
// out_valid is raised when the result is loaded into the output register. Each probe is a
// registered read of the source and target memories followed by a compare state.
// One item is in flight at a time; the next is taken once the result has moved into the
// output register and the sequencer has returned to idle.
// When the receiver stalls, the result holds in the output register; a finished item
// waits until that register frees up, and in_stall stays high meanwhile.
// Reset clears the control state and entry_count; the table is not cleared and an
// entry must be written before a lookup can reach it.
module address_redirect_binary_search_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ADDR_WIDTH  = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [arbs_pkg::INDEX_W-1:0] entry_index,
	input  logic [ADDR_WIDTH-1:0]        entry_source,
	input  logic [ADDR_WIDTH-1:0]        entry_target,
	input  logic [ADDR_WIDTH-1:0]        lookup_address,
	input  logic                         is_owner,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ADDR_WIDTH-1:0]        result_address,
	output logic                         hit,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [arbs_pkg::COUNT_W-1:0] entry_count
);

	arbs_pkg::arbs_cmd_t  cmd;
	arbs_pkg::arbs_stat_t stat;

	assign cfg_ready = 1'b1;

	arbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	arbs_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_count      (entry_count),
		.command        (command),
		.entry_index    (entry_index),
		.entry_source   (entry_source),
		.entry_target   (entry_target),
		.lookup_address (lookup_address),
		.is_owner       (is_owner),
		.result_address (result_address),
		.hit            (hit)
	);

endmodule
